### sv/stream_find_replace_all_macros.svh
// assertion macros for the stream find and replace block
`ifndef STREAM_FIND_REPLACE_ALL_MACROS_SVH
`define STREAM_FIND_REPLACE_ALL_MACROS_SVH
`ifndef SYNTHESIS
`define SFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sfr assertion failed");
`define SFR_ASSERT_IMPLY(lbl, a, b) `SFR_ASSERT(lbl, (a) |-> (b))
`else
`define SFR_ASSERT(lbl, prop)
`define SFR_ASSERT_IMPLY(lbl, a, b)
`endif
`endif

### sv/sfr_pkg.sv
// shared types and constants of the stream find and replace block
package sfr_pkg;

    localparam int WIN_MAX = 8;
    localparam int WIN_IDX_W = $clog2(WIN_MAX);
    localparam int STEP_W = 5;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES     = 3'd0,
        REG_PATTERN_LEN       = 3'd1,
        REG_REPLACEMENT_BYTES = 3'd2,
        REG_REPLACEMENT_LEN   = 3'd3,
        REG_OUT_SIZE          = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_len;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_len;
        logic [15:0] out_size;
    } t_cfg;

    // one classified input word: bytes to release, optional replacement, optional end
    typedef struct packed {
        logic [WIN_MAX-1:0][7:0] win;
        logic [3:0]              wcnt;
        logic                    rep;
        logic                    last;
        logic [STEP_W-1:0]       steps;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### sv/sfr_if.sv
// stream and configuration channel interfaces
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] content_byte;
    logic       content_last;
    modport source (output valid, output content_byte, output content_last, input ready);
    modport sink (input valid, input content_byte, input content_last, output ready);
endinterface

interface sfr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_present;
    logic        run_last;
    logic        content_done;
    logic [31:0] required_len;
    modport source (output valid, output out_byte, output byte_present, output run_last,
                    output content_done, output required_len, input ready);
    modport sink (input valid, input out_byte, input byte_present, input run_last,
                  input content_done, input required_len, output ready);
endinterface

interface sfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/sfr_queue.sv
// two-entry job queue between front and back
module sfr_queue import sfr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qs
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job      = r_mem[r_rp];
    assign o_qs.full  = (r_cnt == 2'd2);
    assign o_qs.empty = (r_cnt == 2'd0);

endmodule

### sv/sfr_front.sv
// front: holds pattern prefix bytes and classifies each content word into a job
module sfr_front import sfr_pkg::*; #(
    parameter int PATTERN_MAX     = 8,
    parameter int REPLACEMENT_MAX = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    sfr_in_if.sink i_in,
    input  t_qstat i_qs,
    output logic   o_push,
    output t_job   o_job
);

    localparam int HC_W = $clog2(PATTERN_MAX);
    localparam int N_W  = $clog2(PATTERN_MAX + 1);

    logic [PATTERN_MAX-2:0][7:0] r_held;
    logic [HC_W-1:0]             r_hc;
    logic [HC_W-1:0]             n_hc;

    logic [PATTERN_MAX-1:0][7:0] held_ext;
    logic [PATTERN_MAX-1:0][7:0] win;
    logic [PATTERN_MAX*8-1:0]    shifted;
    logic [PATTERN_MAX-1:0]      ok;
    logic [N_W-1:0]              n;
    logic [N_W-1:0]              start;
    logic [N_W-1:0]              rem;
    logic [3:0]                  plen;
    logic [3:0]                  rlen;
    logic                        rep;
    logic                        accept;

    assign held_ext   = {8'h00, r_held};
    assign i_in.ready = !i_qs.full;
    assign accept     = i_in.valid && i_in.ready;

    // clamp lengths to the hardware limits
    always_comb begin
        plen = (i_cfg.pattern_len > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX) : i_cfg.pattern_len;
        rlen = (i_cfg.replacement_len > 4'(REPLACEMENT_MAX)) ?
               4'(REPLACEMENT_MAX) : i_cfg.replacement_len;
    end

    // window of held bytes plus the new byte
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (i < int'(r_hc)) win[i] = held_ext[i];
            else if (i == int'(r_hc)) win[i] = i_in.content_byte;
            else win[i] = 8'h00;
        end
        n = N_W'(r_hc) + N_W'(1);
    end

    // parallel prefix checks, one per candidate start
    always_comb begin
        logic [N_W-1:0] len;
        for (int s = 0; s < PATTERN_MAX; s++) begin
            len   = n - N_W'(s);
            ok[s] = (s < int'(n)) && (int'(len) <= int'(plen));
            for (int i = 0; i < PATTERN_MAX - s; i++) begin
                if (i < int'(len) && win[s+i] != i_cfg.pattern_bytes[i*8 +: 8]) ok[s] = 1'b0;
            end
        end
    end

    // leftmost start that is still a prefix
    always_comb begin
        start = n;
        if (plen != 4'd0) begin
            for (int s = PATTERN_MAX - 1; s >= 0; s--) begin
                if (ok[s]) start = N_W'(s);
            end
        end
        rem     = n - start;
        rep     = (plen != 4'd0) && (int'(rem) == int'(plen));
        shifted = win >> {start, 3'b000};
        n_hc    = (rep || i_in.content_last) ? '0 : HC_W'(rem);
    end

    // job for the back end
    always_comb begin
        o_job      = '0;
        o_job.win[PATTERN_MAX-1:0] = win;
        o_job.wcnt = (i_in.content_last && !rep) ? 4'(n) : 4'(start);
        o_job.rep  = rep;
        o_job.last = i_in.content_last;
        o_job.steps = STEP_W'(o_job.wcnt) + (rep ? STEP_W'(rlen) : STEP_W'(0))
                    + STEP_W'(i_in.content_last);
        o_push     = accept && (o_job.steps != '0);
    end

    // held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= '0;
        end else if (accept) begin
            r_hc <= n_hc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_held <= shifted[(PATTERN_MAX-1)*8-1:0];
    end

endmodule

### sv/sfr_back.sv
// back: steps through each job, counts and emits words through an output register
module sfr_back import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_qstat     i_qs,
    input  t_job       i_job,
    output logic       o_pop,
    sfr_out_if.source  o_out
);

    logic [STEP_W-1:0] r_pos;
    logic [15:0]       r_emit;
    logic [31:0]       r_total;
    logic              r_ov;
    logic [7:0]        r_byte;
    logic              r_present;
    logic              r_run_last;
    logic              r_done;
    logic [31:0]       r_len;

    logic [15:0]       lim;
    logic [STEP_W-1:0] rep_idx;
    logic [7:0]        cur_byte;
    logic              is_final;
    logic              is_term;
    logic              present;
    logic              produces;
    logic              go;

    // decode the current step
    always_comb begin
        lim      = (i_cfg.out_size == 16'd0) ? 16'd0 : i_cfg.out_size - 16'd1;
        is_final = (r_pos == i_job.steps - STEP_W'(1));
        is_term  = is_final && i_job.last;
        rep_idx  = r_pos - STEP_W'(i_job.wcnt);
        if (r_pos < STEP_W'(i_job.wcnt)) cur_byte = i_job.win[r_pos[WIN_IDX_W-1:0]];
        else cur_byte = i_cfg.replacement_bytes[{rep_idx[WIN_IDX_W-1:0], 3'b000} +: 8];
        present  = (r_emit < lim);
        produces = is_term || present;
        go       = !i_qs.empty && (!produces || !r_ov || o_out.ready);
        o_pop    = go && is_final;
    end

    // step position, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_emit  <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            // output valid: set on a produced word, cleared when taken
            if (go && produces) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
            if (go) begin
                r_pos <= is_final ? '0 : r_pos + STEP_W'(1);
                if (is_term) begin
                    r_emit  <= '0;
                    r_total <= '0;
                end else begin
                    if (r_total != '1) r_total <= r_total + 32'd1;
                    if (present) r_emit <= r_emit + 16'd1;
                end
            end
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (go && produces) begin
            r_byte     <= is_term ? 8'h00 : cur_byte;
            r_present  <= !is_term;
            r_done     <= is_term;
            r_len      <= is_term ? r_total : 32'd0;
            r_run_last <= is_term || (!i_job.last && (is_final || (r_emit + 16'd1 == lim)));
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_byte     = r_byte;
    assign o_out.byte_present = r_present;
    assign o_out.run_last     = r_run_last;
    assign o_out.content_done = r_done;
    assign o_out.required_len = r_len;

endmodule

### sv/stream_find_replace_all.sv
// top level of the stream find and replace block
// Content bytes enter on i_in, one word per byte, with content_last on the final
// byte. Every leftmost non-overlapping match of the pattern is replaced; bytes that
// may still start a match are held in the front until they are resolved.
// Results leave on o_out: byte words (byte_present high) and, after the final byte,
// one terminal word with content_done high and the full required length.
// run_last marks the last word caused by one input byte. Bytes after the first
// out_size-1 are counted but not sent. Registers are written on i_cfg (always
// ready); the user must do so only while idle, which the block does not enforce.
// An accepted byte's job is written into the job queue, and the back end then
// registers its first word in the output register. The back end takes one step
// per released, replacement or suppressed byte and terminal word; a byte that
// releases at most one byte sustains one byte per cycle unless o_out stalls.
// A two-entry job queue lets the front keep accepting while the back drains a
// longer run. A stall on o_out holds the output register and, once the queue
// fills, i_in.ready. Reset clears the held byte count, the counters and the
// queue, and loads the register reset values (out_size 65535, all others zero).
`include "stream_find_replace_all_macros.svh"
module stream_find_replace_all import sfr_pkg::*; #(
    parameter int PATTERN_MAX     = 8,
    parameter int REPLACEMENT_MAX = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfr_cfg_if.sink   i_cfg,
    sfr_in_if.sink    i_in,
    sfr_out_if.source o_out
);

    t_cfg   r_cfg;
    t_job   w_push_job;
    t_job   w_head_job;
    t_qstat w_qs;
    logic   w_push;
    logic   w_pop;

    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pattern_bytes: '0, pattern_len: '0, replacement_bytes: '0,
                       replacement_len: '0, out_size: 16'hFFFF};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PATTERN_BYTES:     r_cfg.pattern_bytes     <= i_cfg.data;
                REG_PATTERN_LEN:       r_cfg.pattern_len       <= i_cfg.data[3:0];
                REG_REPLACEMENT_BYTES: r_cfg.replacement_bytes <= i_cfg.data;
                REG_REPLACEMENT_LEN:   r_cfg.replacement_len   <= i_cfg.data[3:0];
                REG_OUT_SIZE:          r_cfg.out_size          <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    sfr_front #(
        .PATTERN_MAX     (PATTERN_MAX),
        .REPLACEMENT_MAX (REPLACEMENT_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_qs    (w_qs),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_qs    (w_qs)
    );

    sfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_qs    (w_qs),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // checks
    `SFR_ASSERT_IMPLY(a_term_is_last, o_out.valid && o_out.content_done,
                      o_out.run_last && !o_out.byte_present)
    `SFR_ASSERT_IMPLY(a_byte_no_len, o_out.valid && o_out.byte_present,
                      o_out.required_len == 32'd0 && !o_out.content_done)
    `SFR_ASSERT(a_queue_level, !(w_qs.full && w_qs.empty))

endmodule
